FILE: rtl/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg: shared types and constants of the periodic task dispatcher
// Holds the table size, request and status codes and the structs that
// travel between the dispatcher control and its row of task cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TICK_W    = 32;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_CREATE  = 2'd1;
  localparam logic [1:0] REQ_SUSPEND = 2'd2;
  localparam logic [1:0] REQ_RESUME  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // scan token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic              active;
    logic [TICK_W-1:0] now;
  } tok_t;

  // table write command for one cell
  typedef struct packed {
    logic              create;
    logic              set_susp;
    logic              susp_val;
    logic [TICK_W-1:0] period;
  } wr_t;

endpackage

`default_nettype wire

FILE: rtl/pdt_cell.sv
// ----------------------------------------------------------------------------
// pdt_cell: one task entry of the dispatcher table
// Stores period, last run tick and suspended mark. When the scan token
// sits in this cell it checks whether the task is due and, if so, records
// the tick as its last run; it passes the token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pdt_pkg::tok_t tok_i,
  output pdt_pkg::tok_t      tok_o,
  input  wire pdt_pkg::wr_t  wr_i,
  input  wire logic          live_i,
  output logic               due_o
);

  pdt_pkg::tok_t                    tok_r;
  logic [pdt_pkg::TICK_W-1:0]       period_r;
  logic [pdt_pkg::TICK_W-1:0]       last_r;
  logic                             susp_r;
  logic [pdt_pkg::TICK_W-1:0]       elapsed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_i;
    end
  end

  // wrapped distance since last run
  assign elapsed = tok_r.now - last_r;
  assign due_o   = tok_r.active & live_i & ~susp_r & (elapsed >= period_r);
  assign tok_o   = tok_r;

  always_ff @(posedge clk) begin
    if (wr_i.create) begin
      period_r <= wr_i.period;
      last_r   <= '0;
      susp_r   <= 1'b0;
    end else begin
      if (wr_i.set_susp) begin
        susp_r <= wr_i.susp_val;
      end
      if (due_o) begin
        last_r <= tok_r.now;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher: cooperative periodic task scheduler
// Keeps a row of task cells and sweeps a tick token through them, one
// cell per cycle, reporting each due task in index order.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | start, busy            | in_req_type, in_period, in_task_id
//  result   | out_strobe (no stall)  | out_status, out_due_valid, out_due_task,
//           |                        | out_last_of_run
//  config   | cfg_we                 | cfg_wdata (enable)
//
//  Create, suspend, resume and disabled ticks: result beat in the cycle
//  after the accepting edge; the next item may be accepted at the edge
//  that takes that beat.
//  Enabled tick: the token walks MAX_TASKS cells, one per cycle, so busy
//  stays high through ST_SCAN and ST_DONE; the final beat leaves in the
//  cycle that busy drops, and the next item may be accepted at the edge
//  that takes it. The length of the cell row sets the length of the scan.
//  Synchronous reset clears the counter, task count, enable and control;
//  table entries are written by create before they are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_dispatcher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_period,
  input  wire logic [7:0]  in_task_id,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic             out_due_valid,
  output logic [3:0]       out_due_task,
  output logic             out_last_of_run,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  localparam int N = pdt_pkg::MAX_TASKS;

  pdt_pkg::state_t                state_r, state_nxt;
  logic [pdt_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic [pdt_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [pdt_pkg::IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                           pend_r, pend_nxt;
  logic [pdt_pkg::IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                           enable_r;

  logic                           out_strobe_r, out_strobe_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;
  logic                           out_due_valid_r, out_due_valid_nxt;
  logic [3:0]                     out_due_task_r, out_due_task_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           accept;
  logic                           do_create;
  logic                           do_susp;
  logic                           id_ok;
  logic                           due_any;
  pdt_pkg::tok_t                  launch;
  pdt_pkg::tok_t                  tok  [N];
  pdt_pkg::wr_t                   wr   [N];
  logic [N-1:0]                   live;
  logic [N-1:0]                   due;

  assign busy    = (state_r != pdt_pkg::ST_IDLE);
  assign accept  = start & ~busy;
  assign id_ok   = ({1'b0, in_task_id} < 9'(count_r));
  assign due_any = |due;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign live[i] = (count_r > pdt_pkg::CNT_W'(i));
    if (i == 0) begin : g_head
      pdt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_i  (launch),
        .tok_o  (tok[i]),
        .wr_i   (wr[i]),
        .live_i (live[i]),
        .due_o  (due[i])
      );
    end else begin : g_body
      pdt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_i  (tok[i-1]),
        .tok_o  (tok[i]),
        .wr_i   (wr[i]),
        .live_i (live[i]),
        .due_o  (due[i])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      wr[i].create   = do_create & (count_r == pdt_pkg::CNT_W'(i));
      wr[i].set_susp = do_susp & ({1'b0, in_task_id} == 9'(i));
      wr[i].susp_val = (in_req_type == pdt_pkg::REQ_SUSPEND);
      wr[i].period   = in_period;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pdt_pkg::ST_IDLE;
      tick_r       <= '0;
      count_r      <= '0;
      enable_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      scan_idx_r   <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pend_r       <= pend_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r      <= pend_idx_nxt;
    out_status_r    <= out_status_nxt;
    out_due_valid_r <= out_due_valid_nxt;
    out_due_task_r  <= out_due_task_nxt;
    out_last_r      <= out_last_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    tick_nxt          = tick_r;
    count_nxt         = count_r;
    scan_idx_nxt      = scan_idx_r;
    pend_nxt          = pend_r;
    pend_idx_nxt      = pend_idx_r;
    out_strobe_nxt    = 1'b0;
    out_status_nxt    = pdt_pkg::STAT_OK;
    out_due_valid_nxt = 1'b0;
    out_due_task_nxt  = '0;
    out_last_nxt      = 1'b1;
    do_create         = 1'b0;
    do_susp           = 1'b0;
    launch.active     = 1'b0;
    launch.now        = tick_r;

    case (state_r)
      pdt_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            pdt_pkg::REQ_TICK: begin
              if (enable_r) begin
                launch.active = 1'b1;
                tick_nxt      = tick_r + 1'b1;
                scan_idx_nxt  = '0;
                pend_nxt      = 1'b0;
                state_nxt     = pdt_pkg::ST_SCAN;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            pdt_pkg::REQ_CREATE: begin
              out_strobe_nxt = 1'b1;
              if (count_r >= pdt_pkg::CNT_W'(N)) begin
                out_status_nxt = pdt_pkg::STAT_FULL;
              end else begin
                do_create = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              if (id_ok) begin
                do_susp = 1'b1;
              end else begin
                out_status_nxt = pdt_pkg::STAT_INVALID;
              end
            end
          endcase
        end
      end
      pdt_pkg::ST_SCAN: begin
        // hold one due task back so the final beat can carry last_of_run
        if (due_any) begin
          if (pend_r) begin
            out_strobe_nxt    = 1'b1;
            out_due_valid_nxt = 1'b1;
            out_due_task_nxt  = 4'(pend_idx_r);
            out_last_nxt      = 1'b0;
          end
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r;
        end
        if (scan_idx_r == pdt_pkg::IDX_W'(N - 1)) begin
          state_nxt = pdt_pkg::ST_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      pdt_pkg::ST_DONE: begin
        out_strobe_nxt    = 1'b1;
        out_due_valid_nxt = pend_r;
        out_due_task_nxt  = pend_r ? 4'(pend_idx_r) : 4'd0;
        pend_nxt          = 1'b0;
        state_nxt         = pdt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pdt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_due_valid   = out_due_valid_r;
  assign out_due_task    = out_due_task_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

FILE: dv/periodic_task_dispatcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_tb: self-checking bench for the task dispatcher
// A queue of requests feeds a falling-edge driver. Every accepted beat runs
// through a scheduler model kept in the bench: task table, tick counter and
// enable. Each strobed result is compared against the oldest prediction.
// Directed requests come first, then random segments with enable toggled
// between them while the block is quiet.
// ----------------------------------------------------------------------------

module periodic_task_dispatcher_tb;

  localparam int SETTLE_CYCLES  = pdt_pkg::MAX_TASKS + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] period;
    logic [7:0]  id;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       due_valid;
    logic [3:0] due_task;
    logic       last;
  } dispatch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = pdt_pkg::REQ_TICK;
  logic [31:0] in_period = '0;
  logic [7:0]  in_task_id = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic        out_due_valid;
  logic [3:0]  out_due_task;
  logic        out_last_of_run;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // scheduler model
  logic [31:0] tick_now = '0;
  int          tbl_count = 0;
  logic [31:0] tbl_period [pdt_pkg::MAX_TASKS];
  logic [31:0] tbl_last   [pdt_pkg::MAX_TASKS];
  logic        tbl_susp   [pdt_pkg::MAX_TASKS];
  logic        sched_on = 1'b0;

  sched_req_t  pend_reqs [$];
  dispatch_t   due_q [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  logic        took = 1'b0;
  int          gap_left = 0;
  int          calm_left = 0;

  periodic_task_dispatcher i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_period       (in_period),
    .in_task_id      (in_task_id),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_due_valid   (out_due_valid),
    .out_due_task    (out_due_task),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void push_dispatch(logic [1:0] status, logic due_valid,
                                        logic [3:0] due_task, logic last);
    dispatch_t d;
    d.status    = status;
    d.due_valid = due_valid;
    d.due_task  = due_task;
    d.last      = last;
    due_q.push_back(d);
  endfunction

  function automatic void predict_dispatch(sched_req_t r);
    logic [31:0]                   now;
    logic [31:0]                   elapsed;
    logic [pdt_pkg::MAX_TASKS-1:0] hit;
    int                            last_hit;
    hit = '0;
    last_hit = -1;
    case (r.req)
      pdt_pkg::REQ_TICK: begin
        if (!sched_on) begin
          push_dispatch(pdt_pkg::STAT_OK, 1'b0, 4'd0, 1'b1);
        end else begin
          now = tick_now;
          tick_now = tick_now + 32'd1;
          for (int i = 0; i < tbl_count; i++) begin
            elapsed = now - tbl_last[i];
            if (!tbl_susp[i] && elapsed >= tbl_period[i]) begin
              tbl_last[i] = now;
              hit[i] = 1'b1;
              last_hit = i;
            end
          end
          if (last_hit < 0) begin
            push_dispatch(pdt_pkg::STAT_OK, 1'b0, 4'd0, 1'b1);
          end else begin
            for (int i = 0; i < tbl_count; i++) begin
              if (hit[i]) push_dispatch(pdt_pkg::STAT_OK, 1'b1, i[3:0], i == last_hit);
            end
          end
        end
      end
      pdt_pkg::REQ_CREATE: begin
        if (tbl_count >= pdt_pkg::MAX_TASKS) begin
          push_dispatch(pdt_pkg::STAT_FULL, 1'b0, 4'd0, 1'b1);
        end else begin
          tbl_period[tbl_count] = r.period;
          tbl_last[tbl_count] = '0;
          tbl_susp[tbl_count] = 1'b0;
          tbl_count++;
          push_dispatch(pdt_pkg::STAT_OK, 1'b0, 4'd0, 1'b1);
        end
      end
      default: begin
        if (r.id >= tbl_count) begin
          push_dispatch(pdt_pkg::STAT_INVALID, 1'b0, 4'd0, 1'b1);
        end else begin
          tbl_susp[r.id] = (r.req == pdt_pkg::REQ_SUSPEND);
          push_dispatch(pdt_pkg::STAT_OK, 1'b0, 4'd0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker and acceptance tracking
  always @(posedge clk) begin
    dispatch_t want;
    if (!rst_n) begin
      took <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_strobe) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d due_valid %0b due_task %0d last %0b",
                   $time, out_status, out_due_valid, out_due_task, out_last_of_run);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          check_field("status", 8'(want.status), 8'(out_status));
          check_field("due_valid", 8'(want.due_valid), 8'(out_due_valid));
          check_field("due_task", 8'(want.due_task), 8'(out_due_task));
          check_field("last_of_run", 8'(want.last), 8'(out_last_of_run));
        end
      end
      if (cfg_we) sched_on = cfg_wdata;
      if (start && !busy) predict_dispatch(pend_reqs[0]);
      took <= start && !busy;
      stall_cycles <= (out_strobe || cfg_we || (start && !busy)) ? 0 : stall_cycles + 1;
    end
  end

  // request driver
  always @(negedge clk) begin
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        void'(pend_reqs.pop_front());
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          calm_left = $urandom_range(10, 30);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap_left = 0;
            6, 7, 8:          gap_left = $urandom_range(1, 3);
            default:          gap_left = $urandom_range(6, 40);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        go = 1'b0;
      end else begin
        go = (pend_reqs.size() != 0);
      end
      if (go) begin
        in_req_type <= pend_reqs[0].req;
        in_period   <= pend_reqs[0].period;
        in_task_id  <= pend_reqs[0].id;
      end
      start <= go;
    end
  end

  task automatic queue_req(logic [1:0] req, logic [31:0] period, logic [7:0] id);
    sched_req_t r;
    r.req = req;
    r.period = period;
    r.id = id;
    pend_reqs.push_back(r);
  endtask

  task automatic queue_random_req();
    logic [1:0]  req;
    logic [31:0] period;
    logic [7:0]  id;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: req = pdt_pkg::REQ_TICK;
      10, 11, 12:                   req = pdt_pkg::REQ_CREATE;
      13, 14, 15:                   req = pdt_pkg::REQ_SUSPEND;
      default:                      req = pdt_pkg::REQ_RESUME;
    endcase
    period = $urandom;
    // mostly short periods so tasks come due often
    if (req == pdt_pkg::REQ_CREATE) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: period = $urandom_range(0, 6);
        7, 8:                period = $urandom_range(7, 40);
        default:             period = $urandom;
      endcase
    end
    id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 15));
    queue_req(req, period, id);
  endtask

  task automatic settle();
    while (pend_reqs.size() != 0 || due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int seg_len [4];
    logic seg_en [4];
    seg_len = '{20, 100, 20, 110};
    seg_en = '{1'b0, 1'b1, 1'b0, 1'b1};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // scheduler stopped: ids checked against an empty table
    queue_req(pdt_pkg::REQ_TICK, 32'hFFFF_FFFF, 8'hFF);
    queue_req(pdt_pkg::REQ_SUSPEND, 32'h0, 8'd0);
    queue_req(pdt_pkg::REQ_RESUME, 32'h0, 8'hFF);
    queue_req(pdt_pkg::REQ_CREATE, 32'hFFFF_FFFF, 8'd0);
    queue_req(pdt_pkg::REQ_TICK, 32'h0, 8'd0);
    settle();

    write_enable(1'b1);
    // first tick finds nothing due, then zero period fires every tick
    queue_req(pdt_pkg::REQ_TICK, 32'h0, 8'd0);
    queue_req(pdt_pkg::REQ_CREATE, 32'h0, 8'd0);
    queue_req(pdt_pkg::REQ_CREATE, 32'd1, 8'd0);
    queue_req(pdt_pkg::REQ_CREATE, 32'd3, 8'd0);
    queue_req(pdt_pkg::REQ_TICK, 32'h0, 8'd0);
    queue_req(pdt_pkg::REQ_TICK, 32'h0, 8'd0);
    queue_req(pdt_pkg::REQ_SUSPEND, 32'h0, 8'd1);
    queue_req(pdt_pkg::REQ_TICK, 32'h0, 8'd0);
    queue_req(pdt_pkg::REQ_RESUME, 32'h0, 8'd1);
    queue_req(pdt_pkg::REQ_RESUME, 32'h0, 8'd2);
    queue_req(pdt_pkg::REQ_SUSPEND, 32'h0, 8'd200);
    queue_req(pdt_pkg::REQ_RESUME, 32'h0, 8'd4);
    queue_req(pdt_pkg::REQ_TICK, 32'hFFFF_FFFF, 8'hFF);
    settle();

    for (int s = 0; s < 4; s++) begin
      write_enable(seg_en[s]);
      for (int n = 0; n < seg_len[s]; n++) queue_random_req();
      settle();
    end

    if (mismatches == 0) begin
      $display("periodic_task_dispatcher test passed");
    end else begin
      $display("periodic_task_dispatcher test failed");
    end
    $finish;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("%0t: watchdog expired, nothing accepted for %0d cycles", $time, stall_cycles);
    $display("periodic_task_dispatcher test failed");
    $finish;
  end

endmodule
